[design/rv64m_mul_div_unit_defines.svh]
// ---------------------------------------------------------------------------
// rv64m_mul_div_unit_defines
// Assertion macros for the RV64M multiply/divide unit.
// ---------------------------------------------------------------------------
`ifndef RV64M_MUL_DIV_UNIT_DEFINES_SVH
`define RV64M_MUL_DIV_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RMD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define RMD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("assertion failed");

`endif

[design/rmd_pkg.sv]
// ---------------------------------------------------------------------------
// rmd_pkg
// Shared types and constants of the RV64M multiply/divide unit.
// ---------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned XLen      = 64;
  localparam int unsigned DivStages = XLen;
  localparam int unsigned MulStages = 3;
  localparam int unsigned MulDelay  = DivStages - MulStages;
  localparam int unsigned Latency   = DivStages + 2;

  typedef enum logic [3:0] {
    OP_MUL    = 4'd0,
    OP_MULH   = 4'd1,
    OP_MULHSU = 4'd2,
    OP_MULHU  = 4'd3,
    OP_DIV    = 4'd4,
    OP_DIVU   = 4'd5,
    OP_REM    = 4'd6,
    OP_REMU   = 4'd7,
    OP_MULW   = 4'd8,
    OP_DIVW   = 4'd9,
    OP_DIVUW  = 4'd10,
    OP_REMW   = 4'd11,
    OP_REMUW  = 4'd12
  } op_e;

  // Control carried alongside the divider datapath.
  typedef struct packed {
    logic [3:0]      op;
    logic            word;
    logic            neg_q;
    logic            neg_r;
    logic            dz;
    logic [XLen-1:0] a_eff;
  } side_t;

  // Control for the multiplier.
  typedef struct packed {
    logic sub_b;
    logic sub_a;
    logic high;
    logic word;
  } mctl_t;

  function automatic logic [XLen-1:0] sext32(input logic [XLen-1:0] x);
    return {{(XLen/2){x[XLen/2-1]}}, x[XLen/2-1:0]};
  endfunction

endpackage

[design/rmd_mul.sv]
// ---------------------------------------------------------------------------
// rmd_mul
// Three-stage 64x64 multiplier: partial products, sum, sign fix and select.
// ---------------------------------------------------------------------------
module rmd_mul (
  input  logic                  clk_i,
  input  logic [rmd_pkg::XLen-1:0] a_i,
  input  logic [rmd_pkg::XLen-1:0] b_i,
  input  rmd_pkg::mctl_t        ctl_i,
  output logic [rmd_pkg::XLen-1:0] res_o
);

  localparam int unsigned H = rmd_pkg::XLen / 2;
  localparam int unsigned W = rmd_pkg::XLen;

  logic [W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [W-1:0]   a1_q, b1_q, a2_q, b2_q;
  rmd_pkg::mctl_t c1_q, c2_q;
  logic [2*W-1:0] prod_d, prod_q;
  logic [W-1:0]   res_d, res_q, hi;

  always_ff @(posedge clk_i) begin
    ll_q <= a_i[H-1:0] * b_i[H-1:0];
    lh_q <= a_i[H-1:0] * b_i[W-1:H];
    hl_q <= a_i[W-1:H] * b_i[H-1:0];
    hh_q <= a_i[W-1:H] * b_i[W-1:H];
    a1_q <= a_i;
    b1_q <= b_i;
    c1_q <= ctl_i;
  end

  assign prod_d = {hh_q, ll_q} + ({{W{1'b0}}, lh_q} << H) + ({{W{1'b0}}, hl_q} << H);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    c2_q   <= c1_q;
  end

  always_comb begin
    hi = prod_q[2*W-1:W] - (c2_q.sub_b ? b2_q : '0) - (c2_q.sub_a ? a2_q : '0);
    if (c2_q.word) begin
      res_d = rmd_pkg::sext32(prod_q[W-1:0]);
    end else if (c2_q.high) begin
      res_d = hi;
    end else begin
      res_d = prod_q[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

[design/rmd_div.sv]
// ---------------------------------------------------------------------------
// rmd_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ---------------------------------------------------------------------------
module rmd_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [rmd_pkg::XLen-1:0] n_i,
  input  logic [rmd_pkg::XLen-1:0] d_i,
  input  rmd_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [rmd_pkg::XLen-1:0] q_o,
  output logic [rmd_pkg::XLen-1:0] r_o,
  output rmd_pkg::side_t           side_o
);

  localparam int unsigned W = rmd_pkg::XLen;
  localparam int unsigned S = rmd_pkg::DivStages;

  logic           v_q    [S+1];
  logic [W-1:0]   rem_q  [S+1];
  logic [W-1:0]   nq_q   [S+1];
  logic [W-1:0]   d_q    [S+1];
  rmd_pkg::side_t side_q [S+1];

  assign v_q[0]    = valid_i;
  assign rem_q[0]  = '0;
  assign nq_q[0]   = n_i;
  assign d_q[0]    = d_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [W:0] rs, diff;
    logic       ge;
    assign rs   = {rem_q[k], nq_q[k][W-1]};
    assign diff = rs - {1'b0, d_q[k]};
    assign ge   = ~diff[W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? diff[W-1:0] : rs[W-1:0];
      nq_q[k+1]   <= {nq_q[k][W-2:0], ge};
      d_q[k+1]    <= d_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = v_q[S];
  assign q_o     = nq_q[S];
  assign r_o     = rem_q[S];
  assign side_o  = side_q[S];

endmodule

[design/rv64m_mul_div_unit.sv]
// ---------------------------------------------------------------------------
// rv64m_mul_div_unit
// Pipelined RV64M multiply/divide unit.
// ---------------------------------------------------------------------------
// Usage:
//   Drive operation_i, source_a_i and source_b_i with start high; the
//   transaction is taken on that edge. busy stays low: the unit takes one
//   transaction in every cycle, back to back.
//   Each result appears on dest_value_o and div_zero_flag_o for exactly one
//   cycle with valid_o high, after one operand prep stage, 64 divider
//   stages and one result stage. Every operation has the same latency, so
//   results leave in the order they entered.
//   The depth is set by the divider, which resolves one quotient bit per
//   stage; the multiplier takes three stages and is delayed to match.
//   Undefined operation codes give zero.
//   Reset clears all valid bits; transactions in flight are dropped.
//   The receiver cannot stall the unit and must take every result.
// ---------------------------------------------------------------------------
`include "rv64m_mul_div_unit_defines.svh"

module rv64m_mul_div_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation_i,
  input  logic [63:0] source_a_i,
  input  logic [63:0] source_b_i,
  output logic        valid_o,
  output logic [63:0] dest_value_o,
  output logic        div_zero_flag_o
);

  localparam int unsigned W = rmd_pkg::XLen;
  localparam int unsigned H = W / 2;
  localparam int unsigned D = rmd_pkg::MulDelay;

  logic           word, sgn, sn, sd;
  logic [W-1:0]   a_eff, b_eff;
  logic           v0_q;
  logic [W-1:0]   n0_q, d0_q, ma_q, mb_q;
  rmd_pkg::side_t s0_d, s0_q, sdo;
  rmd_pkg::mctl_t mc_d, mc_q;
  logic           dv;
  logic [W-1:0]   q, r, mres, res_d, pick;
  logic [W-1:0]   dl_q [D];
  logic           vo_q, fo_q, fo_d;
  logic [W-1:0]   ro_q;

  assign busy = 1'b0;

  always_comb begin
    word = (operation_i == rmd_pkg::OP_MULW) || (operation_i == rmd_pkg::OP_DIVW) ||
           (operation_i == rmd_pkg::OP_DIVUW) || (operation_i == rmd_pkg::OP_REMW) ||
           (operation_i == rmd_pkg::OP_REMUW);
    sgn  = (operation_i == rmd_pkg::OP_DIV) || (operation_i == rmd_pkg::OP_REM) ||
           (operation_i == rmd_pkg::OP_DIVW) || (operation_i == rmd_pkg::OP_REMW);
    if (word) begin
      a_eff = sgn ? rmd_pkg::sext32(source_a_i) : {{H{1'b0}}, source_a_i[H-1:0]};
      b_eff = sgn ? rmd_pkg::sext32(source_b_i) : {{H{1'b0}}, source_b_i[H-1:0]};
    end else begin
      a_eff = source_a_i;
      b_eff = source_b_i;
    end
    sn = sgn & a_eff[W-1];
    sd = sgn & b_eff[W-1];
    s0_d.op    = operation_i;
    s0_d.word  = word;
    s0_d.neg_q = sn ^ sd;
    s0_d.neg_r = sn;
    s0_d.dz    = (b_eff == '0);
    s0_d.a_eff = a_eff;
    mc_d.sub_b = source_a_i[W-1] && ((operation_i == rmd_pkg::OP_MULH) ||
                                     (operation_i == rmd_pkg::OP_MULHSU));
    mc_d.sub_a = source_b_i[W-1] && (operation_i == rmd_pkg::OP_MULH);
    mc_d.high  = (operation_i == rmd_pkg::OP_MULH) || (operation_i == rmd_pkg::OP_MULHSU) ||
                 (operation_i == rmd_pkg::OP_MULHU);
    mc_d.word  = (operation_i == rmd_pkg::OP_MULW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    n0_q <= sn ? (~a_eff + 1'b1) : a_eff;
    d0_q <= sd ? (~b_eff + 1'b1) : b_eff;
    s0_q <= s0_d;
    ma_q <= source_a_i;
    mb_q <= source_b_i;
    mc_q <= mc_d;
  end

  rmd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma_q),
    .b_i   (mb_q),
    .ctl_i (mc_q),
    .res_o (mres)
  );

  always_ff @(posedge clk_i) begin
    dl_q[0] <= mres;
    for (int i = 1; i < D; i++) begin
      dl_q[i] <= dl_q[i-1];
    end
  end

  rmd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .n_i     (n0_q),
    .d_i     (d0_q),
    .side_i  (s0_q),
    .valid_o (dv),
    .q_o     (q),
    .r_o     (r),
    .side_o  (sdo)
  );

  always_comb begin
    fo_d = 1'b0;
    pick = '0;
    case (sdo.op)
      rmd_pkg::OP_MUL, rmd_pkg::OP_MULH, rmd_pkg::OP_MULHSU, rmd_pkg::OP_MULHU,
      rmd_pkg::OP_MULW: begin
        pick = dl_q[D-1];
      end
      rmd_pkg::OP_DIV, rmd_pkg::OP_DIVU, rmd_pkg::OP_DIVW, rmd_pkg::OP_DIVUW: begin
        fo_d = sdo.dz;
        pick = sdo.dz ? '1 : (sdo.neg_q ? (~q + 1'b1) : q);
      end
      rmd_pkg::OP_REM, rmd_pkg::OP_REMU, rmd_pkg::OP_REMW, rmd_pkg::OP_REMUW: begin
        pick = sdo.dz ? sdo.a_eff : (sdo.neg_r ? (~r + 1'b1) : r);
      end
      default: begin
        pick = '0;
      end
    endcase
    res_d = (sdo.word && !fo_d) ? rmd_pkg::sext32(pick) : pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
      fo_q <= 1'b0;
    end else begin
      vo_q <= dv;
      fo_q <= dv & fo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ro_q <= res_d;
  end

  assign valid_o         = vo_q;
  assign dest_value_o    = ro_q;
  assign div_zero_flag_o = fo_q;

  `RMD_ASSERT_NEVER(a_flag_valid, clk_i, rst_ni, div_zero_flag_o && !valid_o)
  `RMD_ASSERT_IMP(a_flag_ones, clk_i, rst_ni, valid_o && div_zero_flag_o, dest_value_o == '1)
  `RMD_ASSERT_IMP(a_latency, clk_i, rst_ni, valid_o, $past(start, rmd_pkg::Latency))
  `RMD_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy)

endmodule
